### sv/bla_pkg.sv
package bla_pkg;

    // Field and register widths
    localparam int CODE_W     = 12;
    localparam int PIN_W      = 13;
    localparam int BAT_W      = 16;
    localparam int PCT_W      = 10;
    localparam int GAIN_W     = 17;
    localparam int RATIO_W    = 20;
    localparam int MV_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd66191;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 20'd257206;
    localparam logic [MV_W-1:0]    EMPTY_RESET = 16'd9600;
    localparam logic [MV_W-1:0]    FULL_RESET  = 16'd12600;

    localparam int DEPTH_DEFAULT = 10;

    // Converter scale and percent range
    localparam int ADC_FULL_CODE = 4095;
    localparam int ADC_FULL_MV   = 3300;
    localparam int PCT_MAX       = 1000;

    // Shared divider: remainder and divisor width covers the largest
    // sample-count divisor (4095 * 64) and the 16-bit voltage span.
    localparam int DIV_W     = 18;
    localparam int QUO_W     = 29;  // pin_q16 always fits below 2^29
    localparam int DIV_CNT_W = 5;
    localparam int PCT_BITS  = 11;  // quotient bits for the percent divide

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN  = 2'd0,
        REG_RATIO = 2'd1,
        REG_EMPTY = 2'd2,
        REG_FULL  = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_MUL1,
        ST_MUL2,
        ST_DIV1,
        ST_WAIT1,
        ST_MUL3,
        ST_PCT,
        ST_CHK,
        ST_WAIT2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_req_t;

endpackage

### sv/bla_ring.sv
module bla_ring #(
    parameter int DEPTH = bla_pkg::DEPTH_DEFAULT,
    parameter int SUM_W = 16,
    parameter int CNT_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_valid,
    input  logic [bla_pkg::CODE_W-1:0] push_code,
    output logic                      push_done,
    output logic [SUM_W-1:0]          sum,
    output logic [CNT_W-1:0]          fill
);
    import bla_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rdata_reg;
    logic [CODE_W-1:0] code_reg;
    logic              phase_reg;
    logic              done_reg;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              full;

    // Old entry leaves the sum only once every slot holds a sample.
    assign full = (fill_reg == CNT_W'(DEPTH));

    always_comb
    begin
        slot_next = (slot_reg == IDX_W'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        fill_next = full ? fill_reg : fill_reg + 1'b1;
        sum_next  = sum_reg - (full ? SUM_W'(rdata_reg) : '0) + SUM_W'(code_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            rdata_reg <= mem[slot_reg];
            code_reg  <= push_code;
        end
        if (phase_reg)
        begin
            mem[slot_reg] <= code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            slot_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= push_valid;
            done_reg  <= phase_reg;
            if (phase_reg)
            begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    assign push_done = done_reg;
    assign sum       = sum_reg;
    assign fill      = fill_reg;

endmodule

### sv/bla_div.sv
module bla_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bla_pkg::div_req_t         req,
    input  logic [bla_pkg::DIV_W-1:0] den,
    input  logic [bla_pkg::DIV_W-1:0] rem_init,
    input  logic [bla_pkg::QUO_W-1:0] bits,
    output logic                      busy,
    output logic                      done,
    output logic [bla_pkg::QUO_W-1:0] quo
);
    import bla_pkg::*;

    logic [DIV_W-1:0]     den_reg;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     shf_reg;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // Restoring division, one quotient bit per cycle; remainder stays below den.
    always_comb
    begin
        trial    = {rem_reg, shf_reg[QUO_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= den;
            rem_reg <= rem_init;
            shf_reg <= bits;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[QUO_W-2:0], 1'b0};
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### sv/battery_level_averager_top.sv
// Moving-average battery gauge. Each input transaction carries one 12-bit
// converter code; the block keeps the last DEPTH codes in a small sample
// memory with a running sum, averages over the codes received so far during
// warm-up, and returns one result transaction with the corrected pin voltage,
// the battery voltage (both in mV, the battery value saturating) and the
// charge in tenths of a percent, clamped to 0..1000 (0 when full_mv is not
// above empty_mv). Items are handled one at a time: the next code is taken
// only after the result of the last one has been loaded into the output
// register. The percent is settled without a divide when the battery is at
// or below empty, the span is not positive, or the battery is at least about
// twice the span above empty. The shared one-bit-per-cycle divider runs 29
// steps for the average and 11 steps for the percent; a result register that
// is not taken holds the next item back. A finished result sits in the output
// register while the next code is accepted. Configuration writes are always
// taken.
module battery_level_averager_top #(
    parameter int DEPTH = bla_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bla_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bla_pkg::CODE_W-1:0]     adc_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bla_pkg::PIN_W-1:0]      pin_mv,
    output logic [bla_pkg::BAT_W-1:0]      battery_mv,
    output logic [bla_pkg::PCT_W-1:0]      percent_tenths
);
    import bla_pkg::*;

    // Sum of DEPTH codes and the sample count that divides it
    localparam int SUM_W  = $clog2(DEPTH * ADC_FULL_CODE + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int P1_W   = SUM_W + 12;          // sum * 3300
    localparam int NUM_W  = P1_W + GAIN_W;       // sum * 3300 * gain
    localparam int BAT_QW = QUO_W + RATIO_W - 16; // battery mV in Q16
    localparam int N2_W   = BAT_QW + 10 - 16;     // (bat - lo) * 1000 >> 16

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0]  gain_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [MV_W-1:0]    empty_reg;
    logic [MV_W-1:0]    full_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            ratio_reg <= RATIO_RESET;
            empty_reg <= EMPTY_RESET;
            full_reg  <= FULL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_RATIO: ratio_reg <= cfg_data[RATIO_W-1:0];
                REG_EMPTY: empty_reg <= cfg_data[MV_W-1:0];
                REG_FULL:  full_reg  <= cfg_data[MV_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- sample ring ----------------
    logic             in_fire;
    logic             ring_done;
    logic [SUM_W-1:0] ring_sum;
    logic [CNT_W-1:0] ring_fill;

    assign in_fire = in_valid && in_ready;

    bla_ring #(
        .DEPTH (DEPTH),
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_fire),
        .push_code  (adc_code),
        .push_done  (ring_done),
        .sum        (ring_sum),
        .fill       (ring_fill)
    );

    // ---------------- shared divider ----------------
    div_req_t         div_req;
    logic [DIV_W-1:0] div_den;
    logic [DIV_W-1:0] div_rem;
    logic [QUO_W-1:0] div_bits;
    logic             div_busy;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;

    bla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .den      (div_den),
        .rem_init (div_rem),
        .bits     (div_bits),
        .busy     (div_busy),
        .done     (div_done),
        .quo      (div_quo)
    );

    // ---------------- datapath registers ----------------
    state_t             state_reg, state_next;
    logic [P1_W-1:0]    prod1_reg, prod1_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DIV_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]   pinq_reg, pinq_next;
    logic [BAT_QW-1:0]  batq_reg, batq_next;
    logic [N2_W-1:0]    n2_reg, n2_next;
    logic [MV_W-1:0]    span_reg, span_next;
    logic               zero_reg, zero_next;
    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]   pin_out_reg, pin_out_next;
    logic [BAT_W-1:0]   bat_out_reg, bat_out_next;
    logic [PCT_W-1:0]   pct_out_reg, pct_out_next;

    logic               out_free;
    logic               pct_over;
    logic [BAT_QW-1:0]  lo_q16;
    logic [BAT_QW-1:0]  bat_diff;
    logic [N2_W+15:0]   pct_prod;
    logic [QUO_W+RATIO_W-1:0] bat_prod;

    assign out_free = !out_valid_reg || out_ready;
    // Quotient of 2048 or more: no divide needed, clamp straight away.
    assign pct_over = (n2_reg[N2_W-1:PCT_BITS] >= span_reg);
    assign lo_q16   = BAT_QW'({empty_reg, 16'd0});
    assign bat_diff = batq_reg - lo_q16;
    assign pct_prod = (N2_W + 16)'(bat_diff * (N2_W + 16)'(PCT_MAX));
    assign bat_prod = pinq_reg * ratio_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_PUSH;
            ST_PUSH:  if (ring_done) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_WAIT1;
            ST_WAIT1: if (div_done) state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_PCT;
            ST_PCT:   state_next = ST_CHK;
            ST_CHK:   state_next = (zero_reg || pct_over) ? ST_OUT : ST_WAIT2;
            ST_WAIT2: if (div_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        div_req.start = 1'b0;
        div_req.count = DIV_CNT_W'(QUO_W);
        div_den       = den_reg;
        div_rem       = DIV_W'(num_reg >> QUO_W);
        div_bits      = num_reg[QUO_W-1:0];
        unique case (state_reg)
            ST_DIV1:
            begin
                div_req.start = 1'b1;
            end
            ST_CHK:
            begin
                div_req.start = !(zero_reg || pct_over);
                div_req.count = DIV_CNT_W'(PCT_BITS);
                div_den       = DIV_W'(span_reg);
                div_rem       = DIV_W'(n2_reg[N2_W-1:PCT_BITS]);
                div_bits      = {n2_reg[PCT_BITS-1:0], (QUO_W - PCT_BITS)'(0)};
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        prod1_next     = prod1_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        pinq_next      = pinq_reg;
        batq_next      = batq_reg;
        n2_next        = n2_reg;
        span_next      = span_reg;
        zero_next      = zero_reg;
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pin_out_next   = pin_out_reg;
        bat_out_next   = bat_out_reg;
        pct_out_next   = pct_out_reg;
        case (state_reg)
            ST_MUL1:
            begin
                prod1_next = P1_W'(ring_sum) * P1_W'(ADC_FULL_MV);
                den_next   = DIV_W'(DIV_W'(ring_fill) * DIV_W'(ADC_FULL_CODE));
            end
            ST_MUL2:
            begin
                num_next = NUM_W'(prod1_reg) * NUM_W'(gain_reg);
            end
            ST_WAIT1:
            begin
                if (div_done)
                begin
                    pinq_next = div_quo;
                end
            end
            ST_MUL3:
            begin
                batq_next = bat_prod[QUO_W+RATIO_W-1:16];
            end
            ST_PCT:
            begin
                // compares use the unsaturated battery value
                zero_next = (full_reg <= empty_reg) || (batq_reg <= lo_q16);
                span_next = full_reg - empty_reg;
                n2_next   = pct_prod[N2_W+15:16];
            end
            ST_CHK:
            begin
                pct_next = zero_reg ? '0 : PCT_W'(PCT_MAX);
            end
            ST_WAIT2:
            begin
                if (div_done)
                begin
                    pct_next = (div_quo[PCT_BITS-1:0] > PCT_BITS'(PCT_MAX))
                             ? PCT_W'(PCT_MAX) : div_quo[PCT_W-1:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    // pin_q16 < 2^29, so its integer part always fits 13 bits
                    pin_out_next   = pinq_reg[QUO_W-1:16];
                    bat_out_next   = batq_reg[BAT_QW-1] ? {BAT_W{1'b1}}
                                                        : batq_reg[BAT_QW-2:16];
                    pct_out_next   = pct_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod1_reg   <= prod1_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        pinq_reg    <= pinq_next;
        batq_reg    <= batq_next;
        n2_reg      <= n2_next;
        span_reg    <= span_next;
        zero_reg    <= zero_next;
        pct_reg     <= pct_next;
        pin_out_reg <= pin_out_next;
        bat_out_reg <= bat_out_next;
        pct_out_reg <= pct_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pin_mv         = pin_out_reg;
    assign battery_mv     = bat_out_reg;
    assign percent_tenths = pct_out_reg;

`ifndef SYNTHESIS
    // divider is never restarted while it is still stepping
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // ring finishes its update only while the sequencer waits for it
    a_ring_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ring_done |-> (state_reg == ST_PUSH))
        else $error("ring update outside push phase");

    // divider results arrive only in a wait state
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT1 || state_reg == ST_WAIT2))
        else $error("divider result with no consumer");

    // presented percent is always within range
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent_tenths <= PCT_W'(PCT_MAX)))
        else $error("percent out of range");
`endif

endmodule
